[hw/rtl/bmb_pkg.sv]
// Shared package of the box mean blur block: sizes, the window count function
// and the command/status structs between the controller and the datapath.
// No dependencies.
package bmb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 7;

    // The row store keeps 2*MAX_RADIUS+2 rows; with MAX_RADIUS of 7 that is 16 rows,
    // so the row of an entry is the low bits of the pixel row.
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int ROW_IDX_W  = $clog2(STORE_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 3;
    localparam int TAP_W      = $clog2(2 * MAX_RADIUS + 1);
    localparam int ADDR_W     = ROW_IDX_W + COL_W;
    localparam int ACC_W      = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int DVD_W      = ACC_W + 1;
    localparam int DIV_W      = $clog2(2 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int PIX_W      = 24;

    localparam logic [1:0] REG_RADIUS       = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;

    typedef struct packed {
        logic take_item;
        logic start_sum;
        logic sum_step;
        logic start_div;
        logic div_step;
        logic out_taken;
    } bmb_cmd_t;

    typedef struct packed {
        logic has_out;
        logic taps_done;
        logic div_done;
    } bmb_sts_t;

    // Window pixel count n = (2R+1)^2 for a radius.
    function automatic logic [DIV_W-1:0] win_count(input logic [RAD_W-1:0] r);
        logic [DIV_W-1:0] side;
        side = DIV_W'({r, 1'b1});
        return DIV_W'(side * side);
    endfunction

endpackage

[hw/rtl/bmb_ctrl.sv]
// Controller of the box mean blur block: sequences item intake, window sum,
// division and result delivery. Depends on bmb_pkg.
module bmb_ctrl import bmb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  bmb_sts_t sts,
    output bmb_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_FLUSH,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.take_item  = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
        cmd.start_sum  = (state_reg == ST_CHECK) && sts.has_out;
        cmd.sum_step   = (state_reg == ST_SUM);
        cmd.start_div  = (state_reg == ST_FLUSH);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.out_taken  = (state_reg == ST_OUT) && m_tvalid_reg && m_tready;
        case (state_reg)
            ST_IDLE:  if (cmd.take_item) state_next = ST_CHECK;
            ST_CHECK: state_next = sts.has_out ? ST_SUM : ST_IDLE;
            ST_SUM:   if (sts.taps_done) state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_DIV;
            ST_DIV:   if (sts.div_done) state_next = ST_OUT;
            ST_OUT:   if (cmd.out_taken) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
            m_tvalid_reg <= (state_next == ST_OUT);
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

[hw/rtl/bmb_dp.sv]
// Datapath of the box mean blur block: configuration, frame counters, row
// store, window accumulators and a bit-serial divider per channel. Uses bmb_pkg.
module bmb_dp import bmb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  bmb_cmd_t         cmd,
    output bmb_sts_t         sts,
    output logic [PIX_W-1:0] out_data,
    output logic             out_last
);

    logic [RAD_W-1:0] radius_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [RAD_W-1:0] eff_r_reg;
    logic [DIM_W-1:0] eff_w_reg, eff_h_reg;
    logic [RAD_W-1:0] cur_r;
    logic [DIM_W-1:0] cur_w, cur_h;
    logic [DIM_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             idle;
    logic             store_px;
    logic [DIM_W-1:0] in_col_inc;

    logic [PIX_W-1:0] mem [0:STORE_ROWS*MAX_WIDTH-1];
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    logic [TAP_W-1:0] wr_reg, wc_reg;
    logic [TAP_W-1:0] tap_last;
    logic signed [DIM_W:0] rr, cc;
    logic             inb;

    logic [ACC_W-1:0] acc_reg [3];
    logic [DVD_W-1:0] q_reg [3];
    logic [DIV_W-1:0] rem_reg [3];
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] n_win;
    logic [DIV_W-1:0] divisor;

    logic [DIM_W-1:0] need_r, need_c, lim_r, lim_c;

    always_comb begin
        idle  = (in_row_reg == '0) && (in_col_reg == '0)
             && (out_row_reg == '0) && (out_col_reg == '0);
        cur_r = eff_r_reg;
        cur_w = eff_w_reg;
        cur_h = eff_h_reg;
        if (idle) begin
            cur_r = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
            cur_w = (width_reg == '0) ? DIM_W'(1)
                  : ((width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg);
            cur_h = (height_reg == '0) ? DIM_W'(1)
                  : ((height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg);
        end
        store_px   = (s_tuser == KIND_PIXEL) && (in_row_reg < cur_h);
        in_col_inc = DIM_W'(in_col_reg) + DIM_W'(1);
    end

    // Configuration registers and the frame counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RAD_W'(1);
            width_reg   <= DIM_W'(640);
            height_reg  <= DIM_W'(480);
            eff_r_reg   <= RAD_W'(1);
            eff_w_reg   <= DIM_W'(640);
            eff_h_reg   <= DIM_W'(480);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RADIUS:       radius_reg <= cfg_wdata[RAD_W-1:0];
                    REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (cmd.take_item) begin
                eff_r_reg <= cur_r;
                eff_w_reg <= cur_w;
                eff_h_reg <= cur_h;
                if (store_px) begin
                    if (in_col_inc >= cur_w) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + DIM_W'(1);
                    end else begin
                        in_col_reg <= in_col_inc[COL_W-1:0];
                    end
                end
            end
            if (cmd.out_taken) begin
                if (out_last) begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end else if (DIM_W'(out_col_reg) == eff_w_reg - DIM_W'(1)) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // An output is ready once the last pixel its window needs has been stored.
    always_comb begin
        lim_r  = eff_h_reg - DIM_W'(1);
        lim_c  = eff_w_reg - DIM_W'(1);
        need_r = DIM_W'(out_row_reg) + DIM_W'(eff_r_reg);
        need_c = DIM_W'(out_col_reg) + DIM_W'(eff_r_reg);
        if (need_r > lim_r) need_r = lim_r;
        if (need_c > lim_c) need_c = lim_c;
        sts.has_out = (DIM_W'(out_row_reg) < eff_h_reg)
                   && ((need_r < in_row_reg)
                    || ((need_r == in_row_reg) && (need_c < DIM_W'(in_col_reg))));
        sts.taps_done = (wr_reg == tap_last) && (wc_reg == tap_last);
        sts.div_done  = (cnt_reg == CNT_W'(DVD_W - 1));
        out_last = (DIM_W'(out_col_reg) == lim_c) && (DIM_W'(out_row_reg) == lim_r);
    end

    // Window walk: one tap per cycle, taps outside the frame are skipped.
    always_comb begin
        tap_last = TAP_W'({eff_r_reg, 1'b0});
        rr  = $signed({1'b0, DIM_W'(out_row_reg)}) + $signed({1'b0, DIM_W'(wr_reg)})
            - $signed({1'b0, DIM_W'(eff_r_reg)});
        cc  = $signed({1'b0, DIM_W'(out_col_reg)}) + $signed({1'b0, DIM_W'(wc_reg)})
            - $signed({1'b0, DIM_W'(eff_r_reg)});
        inb = (rr >= 0) && (rr < $signed({1'b0, eff_h_reg}))
           && (cc >= 0) && (cc < $signed({1'b0, eff_w_reg}));
        rd_addr = {rr[ROW_IDX_W-1:0], cc[COL_W-1:0]};
        n_win   = win_count(eff_r_reg);
        divisor = DIV_W'({n_win, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item && store_px) begin
            mem[{in_row_reg[ROW_IDX_W-1:0], in_col_reg}] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.sum_step && inb;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_sum) begin
            wr_reg <= '0;
            wc_reg <= '0;
        end else if (cmd.sum_step) begin
            if (wc_reg == tap_last) begin
                wc_reg <= '0;
                wr_reg <= wr_reg + TAP_W'(1);
            end else begin
                wc_reg <= wc_reg + TAP_W'(1);
            end
        end
        if (cmd.start_div) cnt_reg <= '0;
        else if (cmd.div_step) cnt_reg <= cnt_reg + CNT_W'(1);
    end

    // Per channel: accumulate, then restoring division of 2S+n by 2n.
    // The last tap's read lands in the cycle that loads the divider, so the
    // dividend takes the running sum with that tap folded in.
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        logic [DIV_W:0] trial;
        logic [ACC_W-1:0] acc_sum;
        always_comb trial = {rem_reg[ch], q_reg[ch][DVD_W-1]};
        always_comb acc_sum = acc_reg[ch]
                            + (rd_valid_reg ? ACC_W'(rd_data_reg[8*ch +: 8]) : '0);

        always_ff @(posedge aclk) begin
            if (cmd.start_sum) begin
                acc_reg[ch] <= '0;
            end else if (rd_valid_reg) begin
                acc_reg[ch] <= acc_sum;
            end
            if (cmd.start_div) begin
                q_reg[ch]   <= {acc_sum, 1'b0} + DVD_W'(n_win);
                rem_reg[ch] <= '0;
            end else if (cmd.div_step) begin
                if (trial >= {1'b0, divisor}) begin
                    rem_reg[ch] <= DIV_W'(trial - {1'b0, divisor});
                    q_reg[ch]   <= {q_reg[ch][DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg[ch] <= trial[DIV_W-1:0];
                    q_reg[ch]   <= {q_reg[ch][DVD_W-2:0], 1'b0};
                end
            end
        end
        assign out_data[8*ch +: 8] = q_reg[ch][7:0];
    end

endmodule

[hw/rtl/box_mean_blur_rgb.sv]
// Top level of the box mean blur block: joins the controller and the datapath.
// Depends on bmb_pkg, bmb_ctrl and bmb_dp.
//
// Zero-padded (2R+1)x(2R+1) box mean blur of an RGB888 frame in raster order.
// The block takes one beat at a time. A beat that releases no result is done
// after intake and the check. A beat that releases a result goes through intake
// and check, then walks the window through the single read port of the row
// store, settles the last read, runs the bit-serial divide that rounds the
// mean, and then holds the result until it is taken. Send drain beats (tuser
// high) after the frame to flush the remaining outputs; m_tlast marks the last
// output pixel.
// Registers (radius, frame_width, frame_height at indexes 0, 1, 2) take effect
// at the start of the next frame; the row store needs no clearing after reset.
module box_mean_blur_rgb import bmb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic             s_tuser,   // kind: 0 pixel, 1 drain
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic             m_tlast,   // frame_end
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata
);

    bmb_cmd_t cmd;
    bmb_sts_t sts;

    bmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef ASSERT_OFF
    // Intake and delivery never overlap: one beat is in flight at a time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("intake open while result pending");

    // An accepted beat closes intake for at least the check cycle.
    a_intake_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("intake stayed open");

    // A delivered result returns the block to intake.
    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("no return to intake after result");
`endif

endmodule
